// ===== rtl/core/cvc_pkg.sv =====
// Shared types and constants of the control-variate coefficient block.
// No dependencies; used by every module under rtl/core except cvc_div.
`default_nettype none

package cvc_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MEAN_FRAC  = 24;
    localparam int SCALE_SH   = MEAN_FRAC - FRAC_BITS;
    localparam int X_W        = SAMPLE_W + SCALE_SH;       // sample at mean scale
    localparam int MEAN_W     = 48;
    localparam int DIFF_W     = MEAN_W + 1;
    localparam int MAG_W      = X_W + 2;                   // |sample - mean| fits here
    localparam int CHUNK_W    = MAG_W / 2;
    localparam int PART_W     = MAG_W + CHUNK_W;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int PROD_SHIFT = 2 * MEAN_FRAC - FRAC_BITS;
    localparam int SUM_W      = 64;
    localparam int FLOOR_W    = 32;
    localparam int COEF_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int QS_W       = SUM_W + FRAC_BITS;         // slope dividend / quotient

    localparam longint unsigned DEFAULT_MAX_SAMPLES = 64'd1048576;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(1);

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEGEN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVF   = 2'd3;

    typedef struct packed {
        logic load;         // capture an input transfer
        logic start;        // count the pair, latch deltas, start mean dividers
        logic ovf_set;      // pair arrived with the count full
        logic mean_upd;
        logic dc2_calc;
        logic mul_lo;
        logic mul_hi;
        logic combine;
        logic accum;
        logic sel;          // 0: covariance term, 1: variance term
        logic slope_start;
        logic out_load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic                full;
        logic                mean_done;
        logic                slope_done;
        logic                last;
        logic [STATUS_W-1:0] status;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/cvc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; no package needed.
`default_nettype none

module cvc_div #(
    parameter int NW = 42,
    parameter int DW = 21
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic [NW-1:0]      quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg, dsr_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW:0]      rem_sh, rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {rem_reg, quo_reg[NW-1]};
        ge      = rem_sh >= {1'b0, dsr_reg};
        rem_sub = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_sub[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cvc_datapath.sv =====
// Datapath: running means, covariance and variance sums, split multiplier,
// mean and slope dividers, output register. Uses cvc_pkg and cvc_div.
`default_nettype none

module cvc_datapath
    import cvc_pkg::*;
#(
    parameter longint unsigned MAX_SAMPLES = DEFAULT_MAX_SAMPLES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    input  wire logic [2*SAMPLE_W-1:0] s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  cfg_valid,
    input  wire logic [FLOOR_W-1:0]    cfg_data,
    output logic [COEF_W-1:0]          m_tdata,
    output logic [STATUS_W-1:0]        m_tuser
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic signed [X_W-1:0]    xp_reg, xc_reg;
    logic signed [MEAN_W-1:0] mean_p_reg, mean_c_reg;
    logic signed [SUM_W-1:0]  cov_reg, var_reg;
    logic [CW-1:0]            cnt_reg;
    logic                     ovf_reg, last_reg;
    logic [FLOOR_W-1:0]       floor_reg;
    logic [MAG_W-1:0]         dp_mag_reg, dc_mag_reg, dc2_mag_reg;
    logic                     dp_neg_reg, dc_neg_reg, dc2_neg_reg;
    logic [PART_W-1:0]        plo_reg, phi_reg;
    logic [PROD_W-1:0]        full_reg;
    logic                     slope_neg_reg;
    logic [COEF_W-1:0]        coef_reg;
    logic [STATUS_W-1:0]      status_reg;

    logic signed [DIFF_W-1:0] diff_p, diff_c, mag_p_full, mag_c_full;
    logic [MAG_W-1:0]         mag_p, mag_c, mul_a;
    logic [CHUNK_W-1:0]       mul_b;
    logic [PART_W-1:0]        part;
    logic [SUM_W-1:0]         term, cov_mag;
    logic signed [SUM_W-1:0]  sterm, acc_in, acc_out;
    logic                     term_neg;
    logic [CW-1:0]            cnt_inc;
    logic [MAG_W-1:0]         qp, qc;
    logic [MEAN_W-1:0]        qp_ext, qc_ext;
    logic [QS_W-1:0]          slope_q;
    logic                     mean_done_c, mean_done_ctl, slope_done_c, slope_sat;
    logic [COEF_W-1:0]        slope_coef;
    logic [STATUS_W-1:0]      status_c;

    function automatic logic signed [SUM_W-1:0] add_sat(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W-1:0] s;
        s = a + b;
        if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1])
            s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return s;
    endfunction

    always_comb begin
        diff_p = {{(DIFF_W-X_W){xp_reg[X_W-1]}}, xp_reg} - {mean_p_reg[MEAN_W-1], mean_p_reg};
        diff_c = {{(DIFF_W-X_W){xc_reg[X_W-1]}}, xc_reg} - {mean_c_reg[MEAN_W-1], mean_c_reg};
        mag_p_full = diff_p[DIFF_W-1] ? -diff_p : diff_p;
        mag_c_full = diff_c[DIFF_W-1] ? -diff_c : diff_c;
        mag_p = mag_p_full[MAG_W-1:0];
        mag_c = mag_c_full[MAG_W-1:0];
        cnt_inc = cnt_reg + CW'(1);

        mul_a = cmd.sel ? dc_mag_reg : dp_mag_reg;
        mul_b = cmd.mul_hi ? dc2_mag_reg[MAG_W-1:CHUNK_W] : dc2_mag_reg[CHUNK_W-1:0];
        part  = PART_W'(mul_a) * PART_W'(mul_b);

        // shifted product is below 2^63, so only the sum can saturate
        term     = SUM_W'(full_reg[PROD_W-1:PROD_SHIFT]);
        term_neg = (cmd.sel ? dc_neg_reg : dp_neg_reg) ^ dc2_neg_reg;
        sterm    = term_neg ? -$signed(term) : $signed(term);
        acc_in   = cmd.sel ? var_reg : cov_reg;
        acc_out  = add_sat(acc_in, sterm);

        qp_ext = MEAN_W'(qp);
        qc_ext = MEAN_W'(qc);
        cov_mag = cov_reg[SUM_W-1] ? SUM_W'(-cov_reg) : SUM_W'(cov_reg);

        slope_sat  = |slope_q[QS_W-1:COEF_W-1];
        if (slope_sat)
            slope_coef = slope_neg_reg ? {1'b1, {(COEF_W-1){1'b0}}}
                                       : {1'b0, {(COEF_W-1){1'b1}}};
        else
            slope_coef = slope_neg_reg ? -slope_q[COEF_W-1:0] : slope_q[COEF_W-1:0];

        if (ovf_reg)
            status_c = ST_OVF;
        else if (cnt_reg < CW'(2))
            status_c = ST_FEW;
        else if (var_reg <= 0 || var_reg < $signed({{(SUM_W-FLOOR_W){1'b0}}, floor_reg}))
            status_c = ST_DEGEN;
        else
            status_c = ST_OK;
    end

    cvc_div #(.NW(MAG_W), .DW(CW)) u_div_p (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start),
        .dividend(mag_p), .divisor(cnt_inc), .done(mean_done_c), .quotient(qp)
    );

    // finishes on the same cycle as u_div_p
    cvc_div #(.NW(MAG_W), .DW(CW)) u_div_c (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start),
        .dividend(mag_c), .divisor(cnt_inc), .done(mean_done_ctl), .quotient(qc)
    );

    cvc_div #(.NW(QS_W), .DW(SUM_W)) u_div_s (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.slope_start),
        .dividend({cov_mag, {FRAC_BITS{1'b0}}}), .divisor(var_reg),
        .done(slope_done_c), .quotient(slope_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_p_reg <= '0;
            mean_c_reg <= '0;
            cov_reg    <= '0;
            var_reg    <= '0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            floor_reg  <= FLOOR_RESET;
        end else begin
            if (cfg_valid)
                floor_reg <= cfg_data;
            if (cmd.start)
                cnt_reg <= cnt_inc;
            if (cmd.ovf_set)
                ovf_reg <= 1'b1;
            if (cmd.mean_upd) begin
                mean_p_reg <= mean_p_reg + (dp_neg_reg ? -$signed(qp_ext) : $signed(qp_ext));
                mean_c_reg <= mean_c_reg + (dc_neg_reg ? -$signed(qc_ext) : $signed(qc_ext));
            end
            if (cmd.accum) begin
                if (cmd.sel)
                    var_reg <= acc_out;
                else
                    cov_reg <= acc_out;
            end
            if (cmd.clear) begin
                mean_p_reg <= '0;
                mean_c_reg <= '0;
                cov_reg    <= '0;
                var_reg    <= '0;
                cnt_reg    <= '0;
                ovf_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            xp_reg   <= {s_tdata[SAMPLE_W-1:0], {SCALE_SH{1'b0}}};
            xc_reg   <= {s_tdata[2*SAMPLE_W-1:SAMPLE_W], {SCALE_SH{1'b0}}};
            last_reg <= s_tlast;
        end
        if (cmd.start) begin
            dp_mag_reg <= mag_p;
            dp_neg_reg <= diff_p[DIFF_W-1];
            dc_mag_reg <= mag_c;
            dc_neg_reg <= diff_c[DIFF_W-1];
        end
        if (cmd.dc2_calc) begin
            dc2_mag_reg <= mag_c;
            dc2_neg_reg <= diff_c[DIFF_W-1];
        end
        if (cmd.mul_lo)
            plo_reg <= part;
        if (cmd.mul_hi)
            phi_reg <= part;
        if (cmd.combine)
            full_reg <= PROD_W'(plo_reg) + (PROD_W'(phi_reg) << CHUNK_W);
        if (cmd.slope_start)
            slope_neg_reg <= cov_reg[SUM_W-1];
        if (cmd.out_load) begin
            status_reg <= status_c;
            coef_reg   <= (status_c == ST_OK) ? slope_coef : '0;
        end
    end

    assign stat.full       = cnt_reg >= CW'(MAX_SAMPLES);
    assign stat.mean_done  = mean_done_c & mean_done_ctl;
    assign stat.slope_done = slope_done_c;
    assign stat.last       = last_reg;
    assign stat.status     = status_c;
    assign m_tdata         = coef_reg;
    assign m_tuser         = status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cvc_ctrl.sv =====
// Controller FSM: sequences one sample pair through the datapath and the
// final slope division. Uses cvc_pkg command and status structs.
`default_nettype none

module cvc_ctrl
    import cvc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_UPD   = 4'd3;
    localparam logic [3:0] S_DC2   = 4'd4;
    localparam logic [3:0] S_MLO   = 4'd5;
    localparam logic [3:0] S_MHI   = 4'd6;
    localparam logic [3:0] S_COMB  = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_EVAL  = 4'd9;
    localparam logic [3:0] S_SLOPE = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       sel_reg, sel_next;
    logic       mvalid_reg, mvalid_next;

    always_comb begin
        cmd         = '0;
        cmd.sel     = sel_reg;
        state_next  = state_reg;
        sel_next    = sel_reg;
        s_tready    = 1'b0;
        mvalid_next = mvalid_reg && !m_tready;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.full) begin
                    cmd.ovf_set = 1'b1;
                    state_next  = stat.last ? S_EVAL : S_IDLE;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (stat.mean_done)
                    state_next = S_UPD;
            end
            S_UPD: begin
                cmd.mean_upd = 1'b1;
                state_next   = S_DC2;
            end
            S_DC2: begin
                cmd.dc2_calc = 1'b1;
                sel_next     = 1'b0;
                state_next   = S_MLO;
            end
            S_MLO: begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI: begin
                cmd.mul_hi = 1'b1;
                state_next = S_COMB;
            end
            S_COMB: begin
                cmd.combine = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC: begin
                cmd.accum = 1'b1;
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    state_next = S_MLO;
                end else begin
                    state_next = stat.last ? S_EVAL : S_IDLE;
                end
            end
            S_EVAL: begin
                if (stat.status == ST_OK) begin
                    cmd.slope_start = 1'b1;
                    state_next      = S_SLOPE;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_SLOPE: begin
                if (stat.slope_done)
                    state_next = S_OUT;
            end
            S_OUT: begin
                // output register must be free before it takes the new result
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            sel_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/control_variate_coefficient.sv =====
// Control-variate coefficient, top level: Welford covariance / variance slope.
//
// Input stream: s_tdata carries a primary and a control sample pair, s_tlast
// closes a set. A pair is taken only once the last one is through: a check,
// the two 42-bit restoring dividers (one per mean, run side by side), the
// mean update, the new control difference, then split multiply, combine and
// saturating accumulate, first for the covariance and then for the variance.
// A pair arriving with the count full is only checked and flagged as overflow.
// On a last pair the slope cov/var goes through an 80-bit divider before
// m_tvalid rises; too-few, degenerate and overflow sets skip the
// divider. The result (coefficient in m_tdata, status in m_tuser) sits in an
// output register: a stalled receiver holds it, and the block keeps taking
// pairs until a further result is ready.
// cfg_data writes the variance floor in any cycle; write it only while idle.
// Reset (aresetn low, synchronous) clears all statistics, drops m_tvalid and
// sets the floor to 1. All statistics clear again after every result.
`default_nettype none

module control_variate_coefficient
    import cvc_pkg::*;
#(
    parameter longint unsigned MAX_SAMPLES = DEFAULT_MAX_SAMPLES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [2*SAMPLE_W-1:0] s_tdata,   // [31:0] primary_sample, [63:32] control_sample
    input  wire logic                  s_tlast,   // last_sample
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [COEF_W-1:0]          m_tdata,   // [31:0] coefficient
    output logic [STATUS_W-1:0]        m_tuser,   // [1:0] status
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [FLOOR_W-1:0]    cfg_data   // variance_floor
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    cvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cvc_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for control_variate_coefficient: Welford slope per set.
// Depends on cvc_pkg and the control_variate_coefficient RTL; needs nothing else.
`timescale 1ns / 1ps

module testbench;
    import cvc_pkg::*;

    localparam int MEAN_SHIFT = MEAN_FRAC - FRAC_BITS;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic        last;
        logic [31:0] control;
        logic [31:0] primary;
    } pair_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] coef;
    } slope_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0, s_tlast = 0, m_tready = 0, cfg_valid = 0;
    logic [63:0] s_tdata = '0;
    logic [31:0] cfg_data = '0;
    logic s_tready, m_tvalid, cfg_ready;
    logic [31:0] m_tdata;
    logic [1:0] m_tuser;

    control_variate_coefficient dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    pair_t  pending_pairs[$];
    slope_t expected_slopes[$];
    int errors = 0;
    int send_idle = 0, recv_stall = 0;
    longint cycles = 0;

    // predictor state
    logic [31:0]    floor_reg = 32'd1;
    longint         mean_p = 0, mean_c = 0, cov_sum = 0, var_sum = 0;
    longint         count = 0;
    bit             ovf = 0;

    function automatic longint mul_shift_sat(longint a, longint b);
        logic [127:0] pa, pb, prod;
        logic [127:0] sh;
        longint r;
        pa = (a < 0) ? 128'(-a) : 128'(a);
        pb = (b < 0) ? 128'(-b) : 128'(b);
        prod = pa * pb;
        sh = prod >> PROD_SHIFT;
        if (sh > 128'h7FFF_FFFF_FFFF_FFFF) r = 64'h7FFF_FFFF_FFFF_FFFF;
        else r = longint'(sh[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        longint s;
        s = a + b;
        if (b > 0 && s < a) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (b < 0 && s > a) return 64'h8000_0000_0000_0000;
        return s;
    endfunction

    function automatic logic [31:0] slope_of(longint cov, longint vr);
        logic [63:0] mag, uv, q;
        logic [127:0] fq;
        mag = (cov < 0) ? 64'(-cov) : 64'(cov);
        uv = 64'(vr);
        q = mag / uv;
        if (q >= (64'd1 << (31 - FRAC_BITS)))
            return (cov < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        fq = ({64'd0, mag} << FRAC_BITS) / {64'd0, uv};
        return (cov < 0) ? 32'(-fq[31:0]) : fq[31:0];
    endfunction

    task automatic predict_pair(pair_t it);
        longint xp, xc, dp, dc, dc2;
        slope_t r;
        xp = longint'($signed(it.primary)) <<< MEAN_SHIFT;
        xc = longint'($signed(it.control)) <<< MEAN_SHIFT;
        if (count >= DEFAULT_MAX_SAMPLES) begin
            ovf = 1;
        end else begin
            count++;
            dp = xp - mean_p;
            dc = xc - mean_c;
            mean_c += dc / count;
            mean_p += dp / count;
            dc2 = xc - mean_c;
            cov_sum = add_sat(cov_sum, mul_shift_sat(dp, dc2));
            var_sum = add_sat(var_sum, mul_shift_sat(dc, dc2));
        end
        if (!it.last) return;
        r.coef = '0;
        if (ovf) r.status = ST_OVF;
        else if (count < 2) r.status = ST_FEW;
        else if (var_sum <= 0 || var_sum < longint'({32'd0, floor_reg})) r.status = ST_DEGEN;
        else begin
            r.status = ST_OK;
            r.coef = slope_of(cov_sum, var_sum);
        end
        expected_slopes.push_back(r);
        mean_p = 0; mean_c = 0; cov_sum = 0; var_sum = 0; count = 0; ovf = 0;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_pair(pair_t'({s_tlast, s_tdata[63:32], s_tdata[31:0]}));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle) begin
                    pair_t p;
                    p = pending_pairs.pop_front();
                    s_tvalid <= 1;
                    s_tdata <= {p.control, p.primary};
                    s_tlast <= p.last;
                end else begin
                    s_tvalid <= 0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_slopes.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                slope_t e;
                e = expected_slopes.pop_front();
                if (m_tdata !== e.coef) report_mismatch("coefficient", m_tdata, e.coef);
                if (m_tuser !== e.status) report_mismatch("status", 32'(m_tuser), 32'(e.status));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    task automatic queue_pair(logic [31:0] p, logic [31:0] c, logic l);
        pending_pairs.push_back(pair_t'({l, c, p}));
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() > 0 || s_tvalid || expected_slopes.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_floor(logic [31:0] v);
        @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        floor_reg = v;
    endtask

    task automatic random_sets(int pairs);
        int n, len;
        n = 0;
        while (n < pairs) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 12);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(3) == 0) queue_pair($urandom(), $urandom(), k == len - 1);
                else queue_pair(rand_sample(), rand_sample(), k == len - 1);
            end
            n += len;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        // directed: single pair, extremes, constant control, perfect correlation
        queue_pair(32'h0001_0000, 32'h0002_0000, 1);
        queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 0);
        queue_pair(32'h8000_0000, 32'h7FFF_FFFF, 1);
        queue_pair(32'h0003_0000, 32'h0005_0000, 0);
        queue_pair(32'hFFFF_0000, 32'h0005_0000, 0);
        queue_pair(32'h1234_5678, 32'h0005_0000, 1);
        for (int k = 0; k < 5; k++) queue_pair(32'(k * 3 << 16), 32'(k << 16), k == 4);
        queue_pair(32'h7FFF_FFFF, 32'h0000_0001, 0);
        queue_pair(32'h8000_0000, 32'h0000_0000, 1);
        queue_pair(32'h0000_0000, 32'h0000_0001, 0);
        queue_pair(32'h0000_0000, 32'h0000_0000, 1);
        queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        queue_pair(32'h5555_AAAA, 32'hAAAA_5555, 1);
        wait_idle();

        write_floor(32'hFFFF_FFFF);
        random_sets(60);
        wait_idle();
        write_floor(32'd0);
        recv_stall = 0; send_idle = 0;
        random_sets(150);
        wait_idle();
        send_idle = 55;
        random_sets(130);
        wait_idle();
        write_floor($urandom_range(1 << 24));
        send_idle = 0; recv_stall = 55;
        random_sets(130);
        wait_idle();
        write_floor(32'd1);
        send_idle = 38; recv_stall = 38;
        random_sets(130);
        wait_idle();

        if (errors == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end

endmodule
